// ===== hw/rtl/qst_pkg.sv =====
// qst_pkg: shared types, widths and the rounding helper for the
// quaternion to scaled transform pipeline; no dependencies
`timescale 1ns / 1ps

package qst_pkg;

  // field and datapath widths
  localparam int FIELD_W = 16;                 // Q2.14 and Q8.8 inputs
  localparam int PROD_W  = 2 * FIELD_W;        // Q4.28 quaternion products
  localparam int TERM_W  = PROD_W + 2;         // doubled sums of two products
  localparam int MUL_W   = TERM_W + FIELD_W;   // term times scale or position
  localparam int SAT_W   = MUL_W + 2;          // headroom for the rounding add
  localparam int ELEM_W  = 32;                 // Q16.16 result element
  localparam int ROW_W   = 2;

  // fraction bits dropped on the way to Q16.16
  localparam int unsigned SH_MUL = 20;
  localparam int unsigned SH_NRM = 12;

  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh0000_0000_8000_0000);

  // one input request; first field in the lowest bits, so listed from the top
  typedef struct packed {
    logic signed [FIELD_W-1:0] scale_z;
    logic signed [FIELD_W-1:0] scale_y;
    logic signed [FIELD_W-1:0] scale_x;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] quat_w;
    logic signed [FIELD_W-1:0] quat_z;
    logic signed [FIELD_W-1:0] quat_y;
    logic signed [FIELD_W-1:0] quat_x;
  } qst_item_t;

  // rotation terms (row major), norm, and the pass-through operands
  typedef struct packed {
    logic [8:0][TERM_W-1:0]  rot;
    logic [TERM_W-1:0]       nrm;
    logic [2:0][FIELD_W-1:0] pos;
    logic [2:0][FIELD_W-1:0] scale;
  } qst_terms_t;

  // finished matrix: scaled rotation block, translation column, corner
  typedef struct packed {
    logic [2:0][2:0][ELEM_W-1:0] rs;
    logic [2:0][ELEM_W-1:0]      tr;
    logic [ELEM_W-1:0]           corner;
  } qst_mat_t;

  // round to nearest (ties up) while dropping sh bits, then saturate
  function automatic logic [ELEM_W-1:0] rnd_sat(input logic signed [SAT_W-1:0] v,
                                                input int unsigned sh);
    logic signed [SAT_W-1:0] t;
    logic signed [SAT_W-1:0] q;
    t = v + (SAT_W'(1) <<< (sh - 1));
    q = t >>> sh;
    if (q > SAT_MAX) begin
      rnd_sat = SAT_MAX[ELEM_W-1:0];
    end else if (q < SAT_MIN) begin
      rnd_sat = SAT_MIN[ELEM_W-1:0];
    end else begin
      rnd_sat = q[ELEM_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/qst_quat_terms.sv =====
// qst_quat_terms: stage 1 quaternion products, stage 2 rotation sums and norm
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_quat_terms (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  qst_pkg::qst_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output qst_pkg::qst_terms_t dn_terms
);

  localparam int PW = qst_pkg::PROD_W;
  localparam int TW = qst_pkg::TERM_W;
  localparam int FW = qst_pkg::FIELD_W;

  logic v1_r, v2_r;
  logic en1, en2;

  // stage 1 products (undoubled cross products)
  logic signed [PW-1:0] ww_r, xx_r, yy_r, zz_r;
  logic signed [PW-1:0] xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;
  logic [2:0][FW-1:0]   pos1_r, scl1_r;

  qst_pkg::qst_terms_t terms_nxt, terms_r;

  // stage handshake: a stage loads when empty or when its content moves on
  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= up_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  // stage 1: sixteen-by-sixteen products
  always_ff @(posedge clk) begin
    if (en1) begin
      ww_r   <= up_item.quat_w * up_item.quat_w;
      xx_r   <= up_item.quat_x * up_item.quat_x;
      yy_r   <= up_item.quat_y * up_item.quat_y;
      zz_r   <= up_item.quat_z * up_item.quat_z;
      xy_r   <= up_item.quat_x * up_item.quat_y;
      xz_r   <= up_item.quat_x * up_item.quat_z;
      yz_r   <= up_item.quat_y * up_item.quat_z;
      wx_r   <= up_item.quat_w * up_item.quat_x;
      wy_r   <= up_item.quat_w * up_item.quat_y;
      wz_r   <= up_item.quat_w * up_item.quat_z;
      pos1_r <= {up_item.pos_z, up_item.pos_y, up_item.pos_x};
      scl1_r <= {up_item.scale_z, up_item.scale_y, up_item.scale_x};
    end
  end

  // stage 2: combine squares and doubled cross products
  always_comb begin
    logic signed [TW-1:0] w2, x2, y2, z2;
    logic signed [TW-1:0] dxy, dxz, dyz, dwx, dwy, dwz;
    w2  = TW'(ww_r);
    x2  = TW'(xx_r);
    y2  = TW'(yy_r);
    z2  = TW'(zz_r);
    dxy = TW'(xy_r) <<< 1;
    dxz = TW'(xz_r) <<< 1;
    dyz = TW'(yz_r) <<< 1;
    dwx = TW'(wx_r) <<< 1;
    dwy = TW'(wy_r) <<< 1;
    dwz = TW'(wz_r) <<< 1;
    terms_nxt.rot[0] = w2 + x2 - y2 - z2;
    terms_nxt.rot[1] = dxy + dwz;
    terms_nxt.rot[2] = dxz - dwy;
    terms_nxt.rot[3] = dxy - dwz;
    terms_nxt.rot[4] = w2 + y2 - x2 - z2;
    terms_nxt.rot[5] = dyz + dwx;
    terms_nxt.rot[6] = dxz + dwy;
    terms_nxt.rot[7] = dyz - dwx;
    terms_nxt.rot[8] = w2 + z2 - x2 - y2;
    terms_nxt.nrm    = w2 + x2 + y2 + z2;
    terms_nxt.pos    = pos1_r;
    terms_nxt.scale  = scl1_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      terms_r <= terms_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_terms = terms_r;

endmodule

// ===== hw/rtl/qst_scale_mul.sv =====
// qst_scale_mul: stage 3 scale and norm multiplies, stage 4 rounding and saturation
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_scale_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  qst_pkg::qst_terms_t up_terms,
  output logic                dn_valid,
  input  logic                dn_ready,
  output qst_pkg::qst_mat_t   dn_mat
);

  localparam int TW = qst_pkg::TERM_W;
  localparam int MW = qst_pkg::MUL_W;
  localparam int SW = qst_pkg::SAT_W;
  localparam int FW = qst_pkg::FIELD_W;

  logic v3_r, v4_r;
  logic en3, en4;

  logic [8:0][MW-1:0] rs_nxt, rs_r;
  logic [2:0][MW-1:0] tr_nxt, tr_r;
  logic [TW-1:0]      nrm3_r;

  qst_pkg::qst_mat_t mat_nxt, mat_r;

  // stage handshake
  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) begin
        v3_r <= up_valid;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
    end
  end

  // stage 3: column scale on the rotation block, norm on the translation
  always_comb begin
    logic signed [TW-1:0] ta;
    logic signed [FW-1:0] tb;
    logic signed [MW-1:0] tp;
    rs_nxt = '0;
    tr_nxt = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        ta = up_terms.rot[r*3 + c];
        tb = up_terms.scale[c];
        tp = ta * tb;
        rs_nxt[r*3 + c] = tp;
      end
      ta = up_terms.nrm;
      tb = up_terms.pos[r];
      tp = ta * tb;
      tr_nxt[r] = tp;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      rs_r   <= rs_nxt;
      tr_r   <= tr_nxt;
      nrm3_r <= up_terms.nrm;
    end
  end

  // stage 4: back to Q16.16 with round to nearest and clamp
  always_comb begin
    logic signed [MW-1:0] m;
    logic signed [TW-1:0] n;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m = rs_r[r*3 + c];
        mat_nxt.rs[r][c] = qst_pkg::rnd_sat(SW'(m), qst_pkg::SH_MUL);
      end
      m = tr_r[r];
      mat_nxt.tr[r] = qst_pkg::rnd_sat(SW'(m), qst_pkg::SH_MUL);
    end
    n = nrm3_r;
    mat_nxt.corner = qst_pkg::rnd_sat(SW'(n), qst_pkg::SH_NRM);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      mat_r <= mat_nxt;
    end
  end

  assign dn_valid = v4_r;
  assign dn_mat   = mat_r;

endmodule

// ===== hw/rtl/qst_row_ser.sv =====
// qst_row_ser: holds one finished matrix and sends it out one row per request
// depends on qst_pkg
`timescale 1ns / 1ps

module qst_row_ser (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  qst_pkg::qst_mat_t            up_mat,
  output logic                         row_valid,
  input  logic                         row_ready,
  output logic [qst_pkg::ROW_W-1:0]    row_idx,
  output logic                         row_last,
  output logic [3:0][qst_pkg::ELEM_W-1:0] row_data
);

  logic                      v_r;
  logic [qst_pkg::ROW_W-1:0] cnt_r;
  qst_pkg::qst_mat_t         mat_r;
  logic                      is_last;
  logic                      load;

  // a new matrix may come in as the last row of the current one leaves
  assign is_last  = (cnt_r == qst_pkg::LAST_ROW);
  assign up_ready = !v_r || (row_ready && is_last);
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (up_ready) begin
        v_r   <= up_valid;
        cnt_r <= '0;
      end else if (row_ready) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mat_r <= up_mat;
    end
  end

  // row select; the bottom row is zeros and the norm in the corner
  always_comb begin
    if (is_last) begin
      row_data = {mat_r.corner, {(3*qst_pkg::ELEM_W){1'b0}}};
    end else begin
      row_data = {mat_r.tr[cnt_r], mat_r.rs[cnt_r][2], mat_r.rs[cnt_r][1],
                  mat_r.rs[cnt_r][0]};
    end
  end

  assign row_valid = v_r;
  assign row_idx   = cnt_r;
  assign row_last  = is_last;

endmodule

// ===== hw/rtl/quaternion_to_scaled_transform.sv =====
// quaternion_to_scaled_transform: top level, quaternion + position + scale in,
// four Q16.16 matrix rows out; depends on qst_pkg, qst_quat_terms,
// qst_scale_mul and qst_row_ser
//
//   channel | ports              | contents
//   --------+--------------------+--------------------------------------------
//   input   | in_tvalid/tready   | in_tdata: quaternion, position, scale
//   output  | out_tvalid/tready  | out_tdata: row elements, out_tuser: row,
//           |                    | out_tlast: bottom row
//
// four register stages (products, sums, multiplies, rounding) feed a row
// buffer, which holds one finished matrix and sends it out row by row
// one request yields four output rows; the row buffer sends them out before
// it takes the next matrix, so it sets how often a request can be taken
// the next matrix loads as the bottom row of the previous one leaves
// reset (rst_n low, synchronous) empties every stage; a stall holds all
// stages in place and loses nothing
`timescale 1ns / 1ps

module quaternion_to_scaled_transform (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // quat_x, quat_y, quat_z, quat_w, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_c0, entry_c1, entry_c2, entry_c3
  output logic [127:0] out_tdata,
  // row_index
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  qst_pkg::qst_item_t  item;
  qst_pkg::qst_terms_t terms;
  qst_pkg::qst_mat_t   mat;
  logic                t_valid, t_ready;
  logic                m_valid, m_ready;
  logic [3:0][qst_pkg::ELEM_W-1:0] row_data;

  assign item = qst_pkg::qst_item_t'(in_tdata);

  // products and rotation sums
  qst_quat_terms u_terms (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_item  (item),
    .dn_valid (t_valid),
    .dn_ready (t_ready),
    .dn_terms (terms)
  );

  // scale and norm multiplies, rounding
  qst_scale_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (t_valid),
    .up_ready (t_ready),
    .up_terms (terms),
    .dn_valid (m_valid),
    .dn_ready (m_ready),
    .dn_mat   (mat)
  );

  // row output
  qst_row_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (m_valid),
    .up_ready  (m_ready),
    .up_mat    (mat),
    .row_valid (out_tvalid),
    .row_ready (out_tready),
    .row_idx   (out_tuser),
    .row_last  (out_tlast),
    .row_data  (row_data)
  );

  assign out_tdata = row_data;

endmodule
